// ===== sv/tbps_pkg.sv =====
package tbps_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = $clog2(MAX_PROCS);
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int TIME_BITS = 20;
    localparam int RES_W     = 20;
    localparam int KEY_W     = 16;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // request codes
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_TICK    = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    // policy codes
    localparam logic [2:0] MODE_SRTF    = 3'd0;
    localparam logic [2:0] MODE_PRIO_P  = 3'd1;
    localparam logic [2:0] MODE_SJF     = 3'd2;
    localparam logic [2:0] MODE_PRIO_NP = 3'd3;
    localparam logic [2:0] MODE_FCFS    = 3'd4;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 5;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_COUNT = 1'd1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  entry_index;
        logic [7:0]  burst_time;
        logic [15:0] arrival_time;
        logic [7:0]  priority_level;
    } in_item_t;

    typedef struct packed {
        logic             cpu_idle;
        logic [3:0]       ran_index;
        logic             finished;
        logic [RES_W-1:0] finish_time;
        logic [RES_W-1:0] wait_ticks;
        logic [RES_W-1:0] turnaround_ticks;
        logic             all_done;
    } out_item_t;

    // table access: load writes at the item's index, copy/dec act at idx
    typedef struct packed {
        logic             load;
        logic             copy;
        logic             dec;
        logic [IDX_W-1:0] idx;
    } tbl_cmd_t;

    typedef struct packed {
        logic [7:0]  burst;
        logic [15:0] arrival;
        logic [7:0]  prio;
        logic [7:0]  remaining;
    } tbl_rd_t;

endpackage

// ===== sv/tick_based_process_scheduler.sv =====
// Tick based process scheduler.
// Input channel s_valid/s_ready/s_data carries requests: load one table
// entry (burst, arrival, priority), advance one time tick, or restart the
// run (remaining = burst for every entry, time and running job cleared).
// Only a tick produces a beat on m_valid/m_ready/m_data: the entry that ran
// (or idle), whether it finished, its finish, wait and turnaround times,
// and whether every entry in use is done.
// Configuration (policy_mode, process_count) is written on cfg_we with
// cfg_index/cfg_data while the block is idle. The user must keep to this;
// the block itself does not enforce it. A load writes its entry as it is
// accepted. A restart sweeps the whole table, one entry per cycle. A tick
// scans the entries in use through one key comparator, one per cycle, then
// updates the picked entry and time, works out the wait (skipped when the
// CPU stays idle) and formats the result. s_ready is low during that work.
// The result sits in an output register; the next request is accepted
// while it waits. If the receiver stalls, a later tick waits in its last
// step until the register frees.
// Reset (aresetn, synchronous, active low) clears time, remaining counts
// and running job, sets the configuration to SRTF with one entry in use;
// table parameters are undefined until loaded.
module tick_based_process_scheduler (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  tbps_pkg::in_item_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output tbps_pkg::out_item_t                   m_data,
    input  logic                                  cfg_we,
    input  logic [tbps_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tbps_pkg::CFG_DAT_W-1:0]        cfg_data
);
    import tbps_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SCAN,
        ST_APPLY,
        ST_CALC,
        ST_EMIT
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic [IDX_W-1:0]     run_idx_reg;
    logic                 run_valid_reg;
    logic                 found_reg;
    logic                 hold_reg;
    logic [KEY_W-1:0]     best_reg;
    logic [IDX_W-1:0]     pick_reg;
    logic                 fin_reg;
    logic [16:0]          need_reg;
    logic [7:0]           burst_reg;
    logic [TIME_BITS-1:0] wait_reg;
    logic [2:0]           policy_mode_reg;
    logic [4:0]           process_count_reg;
    logic                 m_valid_reg;
    out_item_t            m_data_reg;

    tbl_cmd_t             tbl_cmd;
    tbl_rd_t              tbl_rd;
    logic [MAX_PROCS-1:0] rem_nz;

    logic                 s_fire;
    logic [CNT_W-1:0]     used_cnt;
    logic [MAX_PROCS-1:0] use_mask;
    logic [2:0]           eff_mode;
    logic                 nonpre;
    logic [KEY_W-1:0]     key;
    logic                 in_range;
    logic                 elig;
    logic                 at_run;
    logic                 wins;
    logic                 out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // entries in use, saturated to the table size
    assign used_cnt = (process_count_reg > 5'(MAX_PROCS)) ? CNT_W'(MAX_PROCS)
                                                          : CNT_W'(process_count_reg);

    always_comb begin
        for (int i = 0; i < MAX_PROCS; i++) begin
            use_mask[i] = (CNT_W'(i) < used_cnt);
        end
    end

    // unused policy codes fall back to FCFS
    assign eff_mode = (policy_mode_reg > MODE_FCFS) ? MODE_FCFS : policy_mode_reg;
    always_comb begin
        nonpre = eff_mode inside {MODE_SJF, MODE_PRIO_NP, MODE_FCFS};
    end

    // table access: scan index, sweep index, or the picked entry
    always_comb begin
        tbl_cmd.load = s_fire && (s_data.req_type == REQ_LOAD);
        tbl_cmd.copy = (state_reg == ST_SWEEP);
        tbl_cmd.dec  = (state_reg == ST_APPLY) && found_reg;
        case (state_reg)
            ST_SWEEP, ST_SCAN: tbl_cmd.idx = cnt_reg[IDX_W-1:0];
            default:           tbl_cmd.idx = pick_reg;
        endcase
    end

    tbps_table u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (tbl_cmd),
        .load_item (s_data),
        .rd        (tbl_rd),
        .rem_nz    (rem_nz)
    );

    // selection key: smaller wins
    always_comb begin
        case (eff_mode)
            MODE_SRTF, MODE_SJF:      key = KEY_W'(tbl_rd.remaining);
            MODE_PRIO_P, MODE_PRIO_NP: key = KEY_W'(tbl_rd.prio);
            default:                  key = KEY_W'(tbl_rd.arrival);
        endcase
    end

    assign in_range = (cnt_reg < used_cnt);
    assign elig     = in_range && (32'(tbl_rd.arrival) <= 32'(time_reg))
                      && (tbl_rd.remaining != 8'd0);
    assign at_run   = run_valid_reg && (cnt_reg[IDX_W-1:0] == run_idx_reg);
    // lowest index wins ties; under SRTF the running job also keeps a tie
    assign wins     = elig && (!found_reg || (key < best_reg)
                      || ((eff_mode == MODE_SRTF) && at_run && (key == best_reg)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            cnt_reg           <= '0;
            time_reg          <= '0;
            run_idx_reg       <= '0;
            run_valid_reg     <= 1'b0;
            found_reg         <= 1'b0;
            hold_reg          <= 1'b0;
            fin_reg           <= 1'b0;
            policy_mode_reg   <= MODE_SRTF;
            process_count_reg <= 5'd1;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_POLICY_MODE:   policy_mode_reg   <= cfg_data[2:0];
                    REG_PROCESS_COUNT: process_count_reg <= cfg_data[4:0];
                    default: ;
                endcase
            end

            // the emit step below reloads the register itself
            if (m_valid_reg && m_ready && (state_reg != ST_EMIT)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    cnt_reg   <= '0;
                    found_reg <= 1'b0;
                    hold_reg  <= 1'b0;
                    fin_reg   <= 1'b0;
                    if (s_fire) begin
                        case (s_data.req_type)
                            REQ_TICK: state_reg <= ST_SCAN;
                            REQ_RESTART: begin
                                time_reg      <= '0;
                                run_idx_reg   <= '0;
                                run_valid_reg <= 1'b0;
                                state_reg     <= ST_SWEEP;
                            end
                            default: ;
                        endcase
                    end
                end

                ST_SWEEP: begin
                    if (cnt_reg == CNT_W'(MAX_PROCS - 1)) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end

                ST_SCAN: begin
                    if (in_range) begin
                        if (wins) begin
                            best_reg  <= key;
                            pick_reg  <= cnt_reg[IDX_W-1:0];
                            found_reg <= 1'b1;
                        end
                        // non-preemptive: an eligible running job keeps the CPU
                        if (elig && at_run && nonpre) begin
                            hold_reg <= 1'b1;
                        end
                        cnt_reg <= cnt_reg + 1'b1;
                    end else begin
                        if (hold_reg) begin
                            pick_reg <= run_idx_reg;
                        end
                        state_reg <= ST_APPLY;
                    end
                end

                ST_APPLY: begin
                    time_reg <= (time_reg == TIME_MAX) ? time_reg
                                                       : time_reg + 1'b1;
                    if (found_reg) begin
                        fin_reg       <= (tbl_rd.remaining == 8'd1);
                        need_reg      <= 17'(tbl_rd.arrival) + 17'(tbl_rd.burst);
                        burst_reg     <= tbl_rd.burst;
                        run_idx_reg   <= pick_reg;
                        run_valid_reg <= (tbl_rd.remaining != 8'd1);
                        state_reg     <= ST_CALC;
                    end else begin
                        run_valid_reg <= 1'b0;
                        state_reg     <= ST_EMIT;
                    end
                end

                ST_CALC: begin
                    // wait = finish - arrival - burst, clamped at zero
                    wait_reg <= (32'(time_reg) > 32'(need_reg))
                                ? TIME_BITS'(32'(time_reg) - 32'(need_reg))
                                : '0;
                    state_reg <= ST_EMIT;
                end

                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg            <= 1'b1;
                        m_data_reg.cpu_idle    <= !found_reg;
                        m_data_reg.ran_index   <= found_reg ? 4'(pick_reg) : 4'd0;
                        m_data_reg.finished    <= fin_reg;
                        m_data_reg.finish_time <= fin_reg ? RES_W'(time_reg) : '0;
                        m_data_reg.wait_ticks  <= fin_reg ? RES_W'(wait_reg) : '0;
                        m_data_reg.turnaround_ticks <=
                            fin_reg ? RES_W'(RES_W'(wait_reg) + RES_W'(burst_reg)) : '0;
                        m_data_reg.all_done    <= ((rem_nz & use_mask) == '0);
                        state_reg              <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.cpu_idle) |-> (!m_data.finished && (m_data.ran_index == 4'd0)))
        else $error("idle beat carries an entry");

    a_turnaround: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.finished) |-> (m_data.turnaround_ticks >= m_data.wait_ticks))
        else $error("turnaround below wait");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (cnt_reg <= used_cnt))
        else $error("scan past entries in use");

    a_emit_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free) |=> (m_valid && state_reg == ST_IDLE))
        else $error("result not registered");

    a_hold_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && hold_reg) |-> found_reg)
        else $error("held job without a pick");
`endif

endmodule

// ===== sv/tbps_table.sv =====
module tbps_table (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  tbps_pkg::tbl_cmd_t                cmd,
    input  tbps_pkg::in_item_t                load_item,
    output tbps_pkg::tbl_rd_t                 rd,
    output logic [tbps_pkg::MAX_PROCS-1:0]    rem_nz
);
    import tbps_pkg::*;

    logic [7:0]           burst_mem   [MAX_PROCS];
    logic [15:0]          arrival_mem [MAX_PROCS];
    logic [7:0]           prio_mem    [MAX_PROCS];
    logic [7:0]           remaining_reg [MAX_PROCS];
    logic [MAX_PROCS-1:0] rem_nz_reg;

    // process parameters: no reset, loaded by the user
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            burst_mem[load_item.entry_index[IDX_W-1:0]]   <= load_item.burst_time;
            arrival_mem[load_item.entry_index[IDX_W-1:0]] <= load_item.arrival_time;
            prio_mem[load_item.entry_index[IDX_W-1:0]]    <= load_item.priority_level;
        end
    end

    // remaining ticks plus a nonzero flag per entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_PROCS; i++) begin
                remaining_reg[i] <= '0;
            end
            rem_nz_reg <= '0;
        end else if (cmd.copy) begin
            remaining_reg[cmd.idx] <= burst_mem[cmd.idx];
            rem_nz_reg[cmd.idx]    <= (burst_mem[cmd.idx] != 8'd0);
        end else if (cmd.dec) begin
            remaining_reg[cmd.idx] <= remaining_reg[cmd.idx] - 8'd1;
            rem_nz_reg[cmd.idx]    <= (remaining_reg[cmd.idx] != 8'd1);
        end
    end

    assign rd.burst     = burst_mem[cmd.idx];
    assign rd.arrival   = arrival_mem[cmd.idx];
    assign rd.prio      = prio_mem[cmd.idx];
    assign rd.remaining = remaining_reg[cmd.idx];
    assign rem_nz       = rem_nz_reg;

endmodule

// ===== tb/tick_based_process_scheduler_tb.sv =====
`timescale 1ns / 1ps

module tick_based_process_scheduler_tb;
    import tbps_pkg::*;

    // request code the block must swallow without a result
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    // policy code past the defined ones, behaves as first come first served
    localparam logic [2:0] MODE_SPARE  = 3'd7;

    localparam int N_REQS     = 1000;  // stimulus stops after this many requests
    localparam int QUIET_CYC  = 40;    // covers a full-table tick or a restart
    localparam int STALL_LIM  = 3000;  // cycles without any beat before giving up
    localparam int SHOW_MAX   = 10;

    // one request on its way to the block, with the result typed in where known
    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } req_beat_t;

    // directed table row: a register write or a request
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_sel;
        logic [CFG_DAT_W-1:0] reg_val;
        req_beat_t            beat;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_item_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_item_t            m_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    tick_based_process_scheduler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Scheduler shadow: configuration, process table and run state
    // ------------------------------------------------------------------
    logic [2:0]           pol_mode  = MODE_SRTF;
    logic [4:0]           proc_cnt  = 5'd1;
    logic [7:0]           tbl_burst [MAX_PROCS];
    logic [15:0]          tbl_arr   [MAX_PROCS];
    logic [7:0]           tbl_prio  [MAX_PROCS];
    logic [7:0]           tbl_rem   [MAX_PROCS];
    logic [TIME_BITS-1:0] now_tick  = '0;
    logic [IDX_W-1:0]     run_idx   = '0;
    bit                   run_on    = 1'b0;
    logic [4:0]           fin_cnt   = '0;

    req_beat_t pending_reqs[$];   // requests not yet handed to the block
    out_item_t due_results[$];    // results owed by the block, oldest first
    bit        tx_busy = 1'b0;    // sender holds a request not yet accepted

    int n_pushed   = 0;
    int n_results  = 0;
    int n_finished = 0;
    int n_idle     = 0;
    int n_cfg      = 0;
    int n_bad      = 0;
    int n_errors   = 0;
    bit [7:0] modes_seen = '0;
    bit [31:0] counts_seen = '0;

    initial begin
        for (int i = 0; i < MAX_PROCS; i++) begin
            tbl_burst[i] = '0;
            tbl_arr[i]   = '0;
            tbl_prio[i]  = '0;
            tbl_rem[i]   = '0;
        end
    end

    function automatic bit can_run(int i, int used);
        return i < used && {4'd0, tbl_arr[i]} <= now_tick && tbl_rem[i] != 0;
    endfunction

    // selection key, smaller wins
    function automatic logic [KEY_W-1:0] pick_key(int i, logic [2:0] pol);
        if (pol == MODE_SRTF || pol == MODE_SJF)
            return {8'd0, tbl_rem[i]};
        if (pol == MODE_PRIO_P || pol == MODE_PRIO_NP)
            return {8'd0, tbl_prio[i]};
        return tbl_arr[i];
    endfunction

    // Applies one request to the shadow; a tick yields one result.
    function automatic void sched_apply(input in_item_t it, output bit has_res,
                                        output out_item_t res);
        int                 used;
        int                 i;
        logic [2:0]         pol;
        bit                 found;
        logic [IDX_W-1:0]   pick;
        logic [KEY_W-1:0]   best;
        logic [KEY_W-1:0]   k;
        logic [TIME_BITS:0] need;
        logic [TIME_BITS:0] wait_v;

        has_res = 1'b0;
        res     = '0;
        used    = (proc_cnt > MAX_PROCS) ? MAX_PROCS : int'(proc_cnt);
        pol     = (pol_mode > MODE_FCFS) ? MODE_FCFS : pol_mode;
        found   = 1'b0;
        pick    = '0;
        best    = '0;

        case (it.req_type)
            REQ_LOAD: begin
                tbl_burst[it.entry_index] = it.burst_time;
                tbl_arr[it.entry_index]   = it.arrival_time;
                tbl_prio[it.entry_index]  = it.priority_level;
            end
            REQ_RESTART: begin
                for (i = 0; i < MAX_PROCS; i++)
                    tbl_rem[i] = tbl_burst[i];
                now_tick = '0;
                run_idx  = '0;
                run_on   = 1'b0;
                fin_cnt  = '0;
            end
            REQ_TICK: begin
                // non-preemptive policies keep the running job while it can run
                if (run_on && (pol == MODE_SJF || pol == MODE_PRIO_NP || pol == MODE_FCFS)
                        && can_run(run_idx, used)) begin
                    pick  = run_idx;
                    found = 1'b1;
                end else begin
                    for (i = 0; i < used; i++) begin
                        if (can_run(i, used)) begin
                            k = pick_key(i, pol);
                            if (!found || k < best) begin
                                best  = k;
                                pick  = i[IDX_W-1:0];
                                found = 1'b1;
                            end
                        end
                    end
                    // shortest remaining: running job wins a tie
                    if (found && pol == MODE_SRTF && run_on && can_run(run_idx, used)
                            && pick_key(run_idx, pol) == best)
                        pick = run_idx;
                end

                if (now_tick != TIME_MAX)
                    now_tick = now_tick + 1'b1;
                has_res = 1'b1;

                if (!found) begin
                    res.cpu_idle = 1'b1;
                    run_on       = 1'b0;
                end else begin
                    tbl_rem[pick] = tbl_rem[pick] - 1'b1;
                    res.ran_index = pick;
                    run_idx       = pick;
                    run_on        = 1'b1;
                    if (tbl_rem[pick] == 0) begin
                        need   = {5'd0, tbl_arr[pick]} + tbl_burst[pick];
                        wait_v = ({1'b0, now_tick} > need) ? {1'b0, now_tick} - need : '0;
                        res.finished         = 1'b1;
                        res.finish_time      = now_tick;
                        res.wait_ticks       = wait_v[RES_W-1:0];
                        res.turnaround_ticks = wait_v[RES_W-1:0] + tbl_burst[pick];
                        run_on = 1'b0;
                        if (fin_cnt != 5'd31)
                            fin_cnt = fin_cnt + 1'b1;
                    end
                end

                res.all_done = 1'b1;
                for (i = 0; i < used; i++)
                    if (tbl_rem[i] != 0)
                        res.all_done = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------
    function automatic in_item_t mk_req(logic [1:0] req, logic [3:0] idx, logic [7:0] burst,
                                        logic [15:0] arr, logic [7:0] prio);
        in_item_t it;
        it.req_type       = req;
        it.entry_index    = idx;
        it.burst_time     = burst;
        it.arrival_time   = arr;
        it.priority_level = prio;
        return it;
    endfunction

    function automatic out_item_t mk_res(bit idle, logic [3:0] idx, bit fin,
                                         logic [RES_W-1:0] ft, logic [RES_W-1:0] wt,
                                         logic [RES_W-1:0] tt, bit done);
        out_item_t r;
        r.cpu_idle         = idle;
        r.ran_index        = idx;
        r.finished         = fin;
        r.finish_time      = ft;
        r.wait_ticks       = wt;
        r.turnaround_ticks = tt;
        r.all_done         = done;
        return r;
    endfunction

    // non-load requests carry junk in the fields the block should ignore
    function automatic in_item_t rand_req(logic [1:0] req);
        return mk_req(req, $urandom, $urandom, $urandom, $urandom);
    endfunction

    // mostly short jobs arriving early, now and then zero or huge bursts
    // and far-off arrivals; priorities often collide to force ties
    function automatic in_item_t rand_load();
        int          r;
        logic [7:0]  burst;
        logic [15:0] arr;
        logic [7:0]  prio;
        r = $urandom_range(0, 99);
        if (r < 5)       burst = 8'd0;
        else if (r < 12) burst = $urandom_range(0, 255);
        else             burst = $urandom_range(1, 6);
        r = $urandom_range(0, 99);
        if (r < 6)       arr = $urandom;
        else             arr = $urandom_range(0, 12);
        r = $urandom_range(0, 99);
        if (r < 50)      prio = $urandom_range(0, 3);
        else             prio = $urandom;
        return mk_req(REQ_LOAD, $urandom, burst, arr, prio);
    endfunction

    function automatic dir_row_t row_req(in_item_t it);
        dir_row_t row;
        row = '{default: '0};
        row.beat.item = it;
        return row;
    endfunction

    function automatic dir_row_t row_chk(in_item_t it, out_item_t want);
        dir_row_t row;
        row = row_req(it);
        row.beat.typed = 1'b1;
        row.beat.want  = want;
        return row;
    endfunction

    function automatic dir_row_t row_cfg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DAT_W-1:0] val);
        dir_row_t row;
        row = '{default: '0};
        row.is_cfg  = 1'b1;
        row.reg_sel = sel;
        row.reg_val = val;
        return row;
    endfunction

    task automatic queue_req(req_beat_t b);
        pending_reqs.push_back(b);
        if (b.item.req_type != REQ_UNKNOWN)
            n_pushed++;
    endtask

    task automatic queue_plain(in_item_t it);
        req_beat_t b;
        b = '{default: '0};
        b.item = it;
        queue_req(b);
    endtask

    // block idle: nothing left to send, nothing owed, and any trailing
    // load/restart/tick has had time to retire
    task automatic wait_idle(int settle);
        while (pending_reqs.size() != 0 || tx_busy || due_results.size() != 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DAT_W-1:0] val);
        wait_idle(QUIET_CYC);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (sel == REG_POLICY_MODE) begin
            pol_mode = val[2:0];
            modes_seen[val[2:0]] = 1'b1;
        end else begin
            proc_cnt = val;
            counts_seen[val] = 1'b1;
        end
        n_cfg++;
    endtask

    // ------------------------------------------------------------------
    // Request sender: bursts of back-to-back beats, random gaps between
    // ------------------------------------------------------------------
    initial begin : sender
        req_beat_t b;
        bit        has_res;
        out_item_t res;
        int        run_left;
        int        gap_left;

        s_valid  = 1'b0;
        s_data   = '0;
        run_left = 0;
        gap_left = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (run_left == 0) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if ($urandom_range(0, 4) == 0) begin
                    run_left = 40;             // long stretch, no gap after it
                    gap_left = 0;
                end else begin
                    run_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                end
            end
            if (run_left != 0 && pending_reqs.size() != 0) begin
                b       = pending_reqs.pop_front();
                tx_busy = 1'b1;
                s_valid <= 1'b1;
                s_data  <= b.item;
                @(posedge aclk);
                while (!s_ready) @(posedge aclk);
                // beat accepted at this edge: advance the shadow
                sched_apply(b.item, has_res, res);
                if (has_res)
                    due_results.push_back(b.typed ? b.want : res);
                tx_busy = 1'b0;
                run_left--;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: stall style changes every so often
    // ------------------------------------------------------------------
    initial begin : receiver
        int rx_style;
        int rx_left;
        int rx_phase;

        m_ready  = 1'b0;
        rx_left  = 0;
        rx_style = 0;
        rx_phase = 0;
        forever begin
            @(negedge aclk);
            if (rx_left == 0) begin
                rx_style = $urandom_range(0, 3);
                rx_left  = $urandom_range(20, 200);
            end
            rx_left--;
            rx_phase = (rx_phase + 1) % 16;
            case (rx_style)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= (rx_phase < 11);  // periodic stall: ready only while rx_phase is below 11
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        out_item_t want;
        bit        bad;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                n_errors++;
                if (n_bad < SHOW_MAX)
                    $display("ERROR %0t: result beat with nothing expected", $time);
                n_bad++;
            end else begin
                want = due_results.pop_front();
                n_results++;
                if (want.finished) n_finished++;
                if (want.cpu_idle) n_idle++;
                bad = (m_data.cpu_idle         !== want.cpu_idle)
                   || (m_data.ran_index        !== want.ran_index)
                   || (m_data.finished         !== want.finished)
                   || (m_data.finish_time      !== want.finish_time)
                   || (m_data.wait_ticks       !== want.wait_ticks)
                   || (m_data.turnaround_ticks !== want.turnaround_ticks)
                   || (m_data.all_done         !== want.all_done);
                if (bad) begin
                    n_errors++;
                    if (n_bad < SHOW_MAX) begin
                        $display("ERROR %0t: tick result %0d mismatch", $time, n_results);
                        $display("  exp idle=%0d run=%0d fin=%0d ft=%0d wt=%0d tt=%0d done=%0d",
                                 want.cpu_idle, want.ran_index, want.finished,
                                 want.finish_time, want.wait_ticks,
                                 want.turnaround_ticks, want.all_done);
                        $display("  got idle=%0d run=%0d fin=%0d ft=%0d wt=%0d tt=%0d done=%0d",
                                 m_data.cpu_idle, m_data.ran_index, m_data.finished,
                                 m_data.finish_time, m_data.wait_ticks,
                                 m_data.turnaround_ticks, m_data.all_done);
                    end
                    n_bad++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run when no beat or write moves for too long
    // ------------------------------------------------------------------
    int stall_cyc = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn)
            stall_cyc <= 0;
        else
            stall_cyc <= stall_cyc + 1;
        if (stall_cyc == STALL_LIM) begin
            $display("TIMEOUT %0t: no beat for %0d cycles, %0d results outstanding",
                     $time, STALL_LIM, due_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        dir_row_t            dir_rows[$];
        int                  r;
        int                  n_load;
        int                  n_step;
        logic [CFG_DAT_W-1:0] mode_v;
        logic [CFG_DAT_W-1:0] cnt_v;

        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_POLICY_MODE;
        cfg_data  = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Fill every table entry before any restart or tick reads it.
        // Entry 0 is a one-tick job at time 0 with top priority; entry 15
        // carries all-ones fields and never arrives in this run.
        queue_plain(mk_req(REQ_LOAD, 4'd0, 8'd1, 16'd0, 8'd0));
        for (int i = 1; i < MAX_PROCS - 1; i++)
            queue_plain(mk_req(REQ_LOAD, i, 2 + i % 5, i % 6, (i * 37) & 8'hFF));
        queue_plain(mk_req(REQ_LOAD, 4'd15, 8'hFF, 16'hFFFF, 8'hFF));

        // Directed part. Out of reset the remaining counts are zero, so a
        // tick before the first restart is idle and everything is done.
        dir_rows.push_back(row_chk(mk_req(REQ_TICK, 0, 0, 0, 0),
                                   mk_res(1, 0, 0, 0, 0, 0, 1)));
        dir_rows.push_back(row_req(mk_req(REQ_RESTART, 0, 0, 0, 0)));
        // one-entry run: entry 0 finishes on the first tick, no wait
        dir_rows.push_back(row_chk(mk_req(REQ_TICK, 0, 0, 0, 0),
                                   mk_res(0, 0, 1, 1, 0, 1, 1)));
        dir_rows.push_back(row_chk(mk_req(REQ_TICK, 0, 0, 0, 0),
                                   mk_res(1, 0, 0, 0, 0, 0, 1)));
        // unknown request with all-ones fields is dropped
        dir_rows.push_back(row_req(mk_req(REQ_UNKNOWN, 4'hF, 8'hFF, 16'hFFFF, 8'hFF)));
        // zero entries in use: always idle, always done
        dir_rows.push_back(row_cfg(REG_PROCESS_COUNT, 5'd0));
        dir_rows.push_back(row_req(mk_req(REQ_RESTART, 0, 0, 0, 0)));
        dir_rows.push_back(row_chk(mk_req(REQ_TICK, 0, 0, 0, 0),
                                   mk_res(1, 0, 0, 0, 0, 0, 1)));
        // count above the table size saturates to a full table
        dir_rows.push_back(row_cfg(REG_PROCESS_COUNT, 5'd31));
        dir_rows.push_back(row_cfg(REG_POLICY_MODE, {2'b00, MODE_SRTF}));
        dir_rows.push_back(row_req(mk_req(REQ_RESTART, 0, 0, 0, 0)));
        repeat (5) dir_rows.push_back(row_req(mk_req(REQ_TICK, 0, 0, 0, 0)));
        // spare policy code falls back to first come first served
        dir_rows.push_back(row_cfg(REG_POLICY_MODE, {2'b00, MODE_SPARE}));
        repeat (3) dir_rows.push_back(row_req(mk_req(REQ_TICK, 0, 0, 0, 0)));
        dir_rows.push_back(row_cfg(REG_POLICY_MODE, {2'b00, MODE_PRIO_P}));
        repeat (2) dir_rows.push_back(row_req(mk_req(REQ_TICK, 0, 0, 0, 0)));
        dir_rows.push_back(row_cfg(REG_POLICY_MODE, {2'b00, MODE_SJF}));
        dir_rows.push_back(row_req(mk_req(REQ_TICK, 0, 0, 0, 0)));
        dir_rows.push_back(row_cfg(REG_POLICY_MODE, {2'b00, MODE_PRIO_NP}));
        repeat (2) dir_rows.push_back(row_req(mk_req(REQ_TICK, 0, 0, 0, 0)));
        // zero-burst entry is done from the restart on and never runs
        dir_rows.push_back(row_cfg(REG_PROCESS_COUNT, MAX_PROCS));
        dir_rows.push_back(row_cfg(REG_POLICY_MODE, {2'b00, MODE_FCFS}));
        dir_rows.push_back(row_req(mk_req(REQ_LOAD, 4'd3, 8'd0, 16'd0, 8'd0)));
        dir_rows.push_back(row_req(mk_req(REQ_RESTART, 0, 0, 0, 0)));
        repeat (2) dir_rows.push_back(row_req(mk_req(REQ_TICK, 0, 0, 0, 0)));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg)
                write_reg(dir_rows[i].reg_sel, dir_rows[i].reg_val);
            else
                queue_req(dir_rows[i].beat);
        end

        // Random part: each phase picks a policy and count, reloads some
        // entries, restarts and runs ticks, with stray loads, restarts and
        // unknown requests mixed in.
        while (n_pushed < N_REQS) begin
            r = $urandom_range(0, 99);
            mode_v = (r < 70) ? $urandom_range(0, 4) : $urandom_range(0, 7);
            r = $urandom_range(0, 99);
            if (r < 8)       cnt_v = 5'd0;
            else if (r < 16) cnt_v = $urandom_range(17, 31);
            else if (r < 40) cnt_v = MAX_PROCS;
            else             cnt_v = $urandom_range(1, MAX_PROCS);
            write_reg(REG_POLICY_MODE, mode_v);
            write_reg(REG_PROCESS_COUNT, cnt_v);

            n_load = $urandom_range(0, MAX_PROCS);
            repeat (n_load) queue_plain(rand_load());
            queue_plain(rand_req(REQ_RESTART));

            n_step = $urandom_range(8, 60);
            repeat (n_step) begin
                r = $urandom_range(0, 99);
                if (r < 4)       queue_plain(rand_req(REQ_UNKNOWN));
                else if (r < 10) queue_plain(rand_load());  // reload mid-run
                else if (r < 12) queue_plain(rand_req(REQ_RESTART));
                else             queue_plain(rand_req(REQ_TICK));
            end
        end

        wait_idle(QUIET_CYC + 20);

        if (due_results.size() != 0)
            n_errors += due_results.size();

        $display("Run: %0d requests, %0d tick results (%0d completions, %0d idle)",
                 n_pushed, n_results, n_finished, n_idle);
        $display("     %0d register writes, policy codes seen 0x%02h, %0d mismatches",
                 n_cfg, modes_seen, n_bad);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== tick_based_process_scheduler.f =====
sv/tbps_pkg.sv
sv/tbps_table.sv
sv/tick_based_process_scheduler.sv
tb/tick_based_process_scheduler_tb.sv
